FILE: sv/salc_pkg.sv
// Shared types and constants of the set-associative cache tag controller.
package salc_pkg;

   localparam int ADDR_W    = 32;
   localparam int STAMP_W   = 64;
   localparam int WAY_MAX_W = 4;

   typedef enum logic {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // outcome of the way scan, valid once every way has been evaluated
   typedef struct packed {
      logic                 hit;
      logic [WAY_MAX_W-1:0] way;
      logic                 line_dirty;   // dirty bit of the hit line
      logic                 evict_dirty;  // victim is valid and dirty
   } scan_type;

endpackage

FILE: sv/salc_if.sv
// Request and response channel interfaces of the cache tag controller.
interface salc_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [salc_pkg::ADDR_W-1:0] address;

   modport source (output valid, cmd, address, input ready);
   modport sink   (input valid, cmd, address, output ready);
endinterface

interface salc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        hit;
   logic [1:0]                  way_used;
   logic                        fetch_request;
   logic                        writeback_request;
   logic [salc_pkg::ADDR_W-1:0] writeback_address;
   logic                        write_through_request;

   modport source (output valid, hit, way_used, fetch_request, writeback_request,
                   writeback_address, write_through_request, input ready);
   modport sink   (input valid, hit, way_used, fetch_request, writeback_request,
                   writeback_address, write_through_request, output ready);
endinterface

FILE: sv/salc_tag_store.sv
// Line state memory (valid, dirty, tag, stamp) with a clearing pass after reset.
module salc_tag_store #(
   parameter int DEPTH = 256,
   parameter int IDX_W = 8,
   parameter int TAG_W = 20
) (
   input  logic                         clock,
   input  logic                         reset,
   output logic                         clearing,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_idx,
   input  logic                         wr_valid,
   input  logic                         wr_dirty,
   input  logic [TAG_W-1:0]             wr_tag,
   input  logic [salc_pkg::STAMP_W-1:0] wr_stamp,
   input  logic                         rd_en,
   input  logic [IDX_W-1:0]             rd_idx,
   output logic                         rd_valid,
   output logic                         rd_dirty,
   output logic [TAG_W-1:0]             rd_tag,
   output logic [salc_pkg::STAMP_W-1:0] rd_stamp
);

   localparam int ENTRY_W = TAG_W + salc_pkg::STAMP_W + 2;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               clear_ff;
   logic               clear_in;
   logic [IDX_W-1:0]   clear_idx_ff;
   logic [IDX_W-1:0]   clear_idx_in;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_idx;
   logic [ENTRY_W-1:0] mem_wdata;

   always_comb begin
      clear_in     = clear_ff;
      clear_idx_in = clear_idx_ff;
      if (clear_ff) begin
         clear_idx_in = clear_idx_ff + IDX_W'(1);
         if (clear_idx_ff == IDX_W'(DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_idx_ff <= '0;
      end else begin
         clear_ff     <= clear_in;
         clear_idx_ff <= clear_idx_in;
      end
   end

   assign mem_we    = clear_ff || wr_en;
   assign mem_idx   = clear_ff ? clear_idx_ff : wr_idx;
   assign mem_wdata = clear_ff ? '0 : {wr_valid, wr_dirty, wr_tag, wr_stamp};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_idx] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

   assign clearing = clear_ff;
   assign {rd_valid, rd_dirty, rd_tag, rd_stamp} = rd_data_ff;

endmodule

FILE: sv/salc_scan_unit.sv
// Shared tag/stamp compare unit: visits one way per strobe, tracks hit and victim.
module salc_scan_unit #(
   parameter int TAG_W = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           strobe,
   input  logic [salc_pkg::WAY_MAX_W-1:0] way,
   input  logic [TAG_W-1:0]               req_tag,
   input  logic                           rd_valid,
   input  logic                           rd_dirty,
   input  logic [TAG_W-1:0]               rd_tag,
   input  logic [salc_pkg::STAMP_W-1:0]   rd_stamp,
   output salc_pkg::scan_type             result,
   output logic [TAG_W-1:0]               victim_tag
);

   logic                           hit_ff, hit_in;
   logic [salc_pkg::WAY_MAX_W-1:0] hit_way_ff, hit_way_in;
   logic                           hit_dirty_ff, hit_dirty_in;
   logic                           inv_ff, inv_in;
   logic [salc_pkg::WAY_MAX_W-1:0] inv_way_ff, inv_way_in;
   logic [salc_pkg::STAMP_W-1:0]   min_stamp_ff, min_stamp_in;
   logic [salc_pkg::WAY_MAX_W-1:0] min_way_ff, min_way_in;
   logic                           min_dirty_ff, min_dirty_in;
   logic [TAG_W-1:0]               min_tag_ff, min_tag_in;

   always_comb begin
      hit_in       = hit_ff;
      hit_way_in   = hit_way_ff;
      hit_dirty_in = hit_dirty_ff;
      inv_in       = inv_ff;
      inv_way_in   = inv_way_ff;
      min_stamp_in = min_stamp_ff;
      min_way_in   = min_way_ff;
      min_dirty_in = min_dirty_ff;
      min_tag_in   = min_tag_ff;
      if (start) begin
         hit_in = 1'b0;
         inv_in = 1'b0;
      end else if (strobe) begin
         // first matching way wins
         if (!hit_ff && rd_valid && (rd_tag == req_tag)) begin
            hit_in       = 1'b1;
            hit_way_in   = way;
            hit_dirty_in = rd_dirty;
         end
         if (!inv_ff && !rd_valid) begin
            inv_in     = 1'b1;
            inv_way_in = way;
         end
         // strict less-than keeps the lowest way on a tie
         if ((way == '0) || (rd_stamp < min_stamp_ff)) begin
            min_stamp_in = rd_stamp;
            min_way_in   = way;
            min_dirty_in = rd_dirty;
            min_tag_in   = rd_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
         inv_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         inv_ff <= inv_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_way_ff   <= hit_way_in;
      hit_dirty_ff <= hit_dirty_in;
      inv_way_ff   <= inv_way_in;
      min_stamp_ff <= min_stamp_in;
      min_way_ff   <= min_way_in;
      min_dirty_ff <= min_dirty_in;
      min_tag_ff   <= min_tag_in;
   end

   always_comb begin
      result.hit         = hit_ff;
      result.line_dirty  = hit_dirty_ff;
      result.evict_dirty = 1'b0;
      if (hit_ff) begin
         result.way = hit_way_ff;
      end else if (inv_ff) begin
         result.way = inv_way_ff;
      end else begin
         result.way         = min_way_ff;
         result.evict_dirty = min_dirty_ff;
      end
   end

   assign victim_tag = min_tag_ff;

endmodule

FILE: sv/set_assoc_cache_lru_controller.sv
// Top level: set-associative cache tag controller with LRU stamps, write-allocate.
// Sequence: per way, READ fetches the line from memory and EVAL passes it through the
//   shared compare unit; UPDATE then writes the line and DONE loads the response
//   once the response slot is free. A new request is accepted only back in IDLE.
// Reset: synchronous; then a clearing pass over all SETS*WAYS lines (256 by default)
//   wipes the line memory, with req_bus.ready low. Write-back mode resets to 1.
module set_assoc_cache_lru_controller #(
   parameter int SETS       = 64,
   parameter int WAYS       = 4,
   parameter int LINE_BYTES = 64
) (
   input  logic          clock,
   input  logic          reset,
   salc_req_if.sink      req_bus,
   salc_rsp_if.source    rsp_bus,
   input  logic          csr_write_enable,
   input  logic          csr_write_data
);

   // geometry; SETS and LINE_BYTES are powers of two
   localparam int OFF_W    = $clog2(LINE_BYTES);
   localparam int SET_BITS = $clog2(SETS);
   localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAG_W    = salc_pkg::ADDR_W - OFF_W - SET_BITS;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int NLINES   = SETS * WAYS;
   localparam int IDX_W    = (NLINES > 1) ? $clog2(NLINES) : 1;

   salc_pkg::state_type state_ff, state_in;

   logic                         wb_mode_ff;
   logic                         cmd_ff;
   logic [SET_W-1:0]             set_ff;
   logic [SET_W-1:0]             req_set;
   logic [TAG_W-1:0]             tag_ff;
   logic [WAY_W-1:0]             way_cnt_ff, way_cnt_in;
   logic [salc_pkg::STAMP_W-1:0] counter_ff;

   logic                         clearing;
   logic                         accept;
   logic                         last_way;
   logic                         write_op;
   logic                         slot_free;

   logic                         rd_en;
   logic [IDX_W-1:0]             rd_idx;
   logic                         rd_valid, rd_dirty;
   logic [TAG_W-1:0]             rd_tag;
   logic [salc_pkg::STAMP_W-1:0] rd_stamp;

   logic                         wr_en;
   logic [IDX_W-1:0]             wr_idx;
   logic                         wr_dirty;

   logic                         scan_start, scan_strobe;
   salc_pkg::scan_type           scan;
   logic [TAG_W-1:0]             victim_tag;
   logic [salc_pkg::ADDR_W-1:0]  victim_addr;

   logic                         rsp_load;
   logic                         rsp_valid_ff;
   logic                         hit_ff;
   logic [1:0]                   way_used_ff;
   logic                         fetch_ff;
   logic                         wb_req_ff;
   logic [salc_pkg::ADDR_W-1:0]  wb_addr_ff;
   logic                         wt_req_ff;

   // address split; tag and block-aligned victim address by bit fields
   generate
      if (SET_BITS > 0) begin : g_sets
         assign req_set     = req_bus.address[OFF_W +: SET_BITS];
         assign victim_addr = {victim_tag, set_ff, {OFF_W{1'b0}}};
      end else begin : g_one_set
         assign req_set     = '0;
         assign victim_addr = {victim_tag, {OFF_W{1'b0}}};
      end
   endgenerate

   assign accept    = req_bus.valid && req_bus.ready;
   assign last_way  = (way_cnt_ff == WAY_W'(WAYS - 1));
   assign write_op  = (cmd_ff == salc_pkg::CMD_WRITE);
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;

   // line index = set * WAYS + way
   assign rd_idx = IDX_W'(set_ff) * IDX_W'(WAYS) + IDX_W'(way_cnt_ff);
   assign wr_idx = IDX_W'(set_ff) * IDX_W'(WAYS) + IDX_W'(WAY_W'(scan.way));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         salc_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = salc_pkg::ST_READ;
            end
         end
         salc_pkg::ST_READ: begin
            state_in = salc_pkg::ST_EVAL;
         end
         salc_pkg::ST_EVAL: begin
            state_in = last_way ? salc_pkg::ST_UPDATE : salc_pkg::ST_READ;
         end
         salc_pkg::ST_UPDATE: begin
            state_in = salc_pkg::ST_DONE;
         end
         salc_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = salc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = salc_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_bus.ready = 1'b0;
      rd_en         = 1'b0;
      scan_start    = 1'b0;
      scan_strobe   = 1'b0;
      wr_en         = 1'b0;
      rsp_load      = 1'b0;
      way_cnt_in    = way_cnt_ff;
      case (state_ff)
         salc_pkg::ST_IDLE: begin
            req_bus.ready = !clearing;
            scan_start    = 1'b1;
            way_cnt_in    = '0;
         end
         salc_pkg::ST_READ: begin
            rd_en = 1'b1;
         end
         salc_pkg::ST_EVAL: begin
            scan_strobe = 1'b1;
            if (!last_way) begin
               way_cnt_in = way_cnt_ff + WAY_W'(1);
            end
         end
         salc_pkg::ST_UPDATE: begin
            wr_en = 1'b1;
         end
         salc_pkg::ST_DONE: begin
            rsp_load = slot_free;
         end
         default: begin
            way_cnt_in = '0;
         end
      endcase
   end

   // a write in write-back mode dirties the line; a hit keeps an existing dirty bit
   assign wr_dirty = (write_op && wb_mode_ff) || (scan.hit && scan.line_dirty);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= salc_pkg::ST_IDLE;
         wb_mode_ff   <= 1'b1;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            wb_mode_ff <= csr_write_data;
         end
         // counter bumps on accept; its new value stamps this access
         if (accept) begin
            counter_ff <= counter_ff + salc_pkg::STAMP_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      way_cnt_ff <= way_cnt_in;
      if (accept) begin
         cmd_ff <= req_bus.cmd;
         set_ff <= req_set;
         tag_ff <= req_bus.address[salc_pkg::ADDR_W-1 -: TAG_W];
      end
      if (rsp_load) begin
         hit_ff      <= scan.hit;
         way_used_ff <= 2'(scan.way);
         fetch_ff    <= !scan.hit;
         wb_req_ff   <= !scan.hit && wb_mode_ff && scan.evict_dirty;
         wb_addr_ff  <= (!scan.hit && wb_mode_ff && scan.evict_dirty) ? victim_addr : '0;
         wt_req_ff   <= write_op && !wb_mode_ff;
      end
   end

   salc_tag_store #(
      .DEPTH (NLINES),
      .IDX_W (IDX_W),
      .TAG_W (TAG_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .wr_en    (wr_en),
      .wr_idx   (wr_idx),
      .wr_valid (1'b1),
      .wr_dirty (wr_dirty),
      .wr_tag   (tag_ff),
      .wr_stamp (counter_ff),
      .rd_en    (rd_en),
      .rd_idx   (rd_idx),
      .rd_valid (rd_valid),
      .rd_dirty (rd_dirty),
      .rd_tag   (rd_tag),
      .rd_stamp (rd_stamp)
   );

   salc_scan_unit #(
      .TAG_W (TAG_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (scan_start),
      .strobe     (scan_strobe),
      .way        (salc_pkg::WAY_MAX_W'(way_cnt_ff)),
      .req_tag    (tag_ff),
      .rd_valid   (rd_valid),
      .rd_dirty   (rd_dirty),
      .rd_tag     (rd_tag),
      .rd_stamp   (rd_stamp),
      .result     (scan),
      .victim_tag (victim_tag)
   );

   assign rsp_bus.valid                 = rsp_valid_ff;
   assign rsp_bus.hit                   = hit_ff;
   assign rsp_bus.way_used              = way_used_ff;
   assign rsp_bus.fetch_request         = fetch_ff;
   assign rsp_bus.writeback_request     = wb_req_ff;
   assign rsp_bus.writeback_address     = wb_addr_ff;
   assign rsp_bus.write_through_request = wt_req_ff;

endmodule
